@@ sv/cube_map_texel_address_defines.svh @@
// assertion macros shared by the cube map texel address block
`ifndef CUBE_MAP_TEXEL_ADDRESS_DEFINES_SVH
`define CUBE_MAP_TEXEL_ADDRESS_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cube map assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("cube map forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ sv/cmta_pkg.sv @@
// types, constants and divider step shared by the cube map texel address block
package cmta_pkg;
    localparam int DIR_W   = 16;
    localparam int COORD_W = 17;
    localparam int DIM_W   = 13;
    localparam int TEX_W   = 12;
    localparam int OFF_W   = 26;
    localparam int SCALE_W = 16;

    localparam logic [2:0] FACE_BOTTOM = 3'd0;
    localparam logic [2:0] FACE_TOP    = 3'd1;
    localparam logic [2:0] FACE_FRONT  = 3'd2;
    localparam logic [2:0] FACE_BACK   = 3'd3;
    localparam logic [2:0] FACE_LEFT   = 3'd4;
    localparam logic [2:0] FACE_RIGHT  = 3'd5;

    localparam logic [1:0] REG_FACE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FACE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_SAMPLE_SCALE = 2'd2;
    localparam logic [1:0] REG_FACE_PRESENT = 2'd3;

    typedef struct packed {
        logic       hit;
        logic [2:0] face;
    } t_side;

    typedef struct packed {
        logic [COORD_W-1:0] rem;
        logic [COORD_W-1:0] low;
        logic [COORD_W-1:0] q;
    } t_lane;

    // one restoring division step, shifting in the top remaining dividend bit
    function automatic t_lane div_step(t_lane l, logic [COORD_W-1:0] d);
        t_lane         o;
        logic [COORD_W:0] sh;
        sh    = {l.rem, l.low[COORD_W-1]};
        o.low = {l.low[COORD_W-2:0], 1'b0};
        if (sh >= {1'b0, d}) begin
            o.rem = COORD_W'(sh - {1'b0, d});
            o.q   = {l.q[COORD_W-2:0], 1'b1};
        end else begin
            o.rem = sh[COORD_W-1:0];
            o.q   = {l.q[COORD_W-2:0], 1'b0};
        end
        return o;
    endfunction
endpackage

@@ sv/cmta_face.sv @@
// face selection and projection numerators, one register stage
module cmta_face import cmta_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [DIR_W-1:0] i_x,
    input  logic signed [DIR_W-1:0] i_y,
    input  logic signed [DIR_W-1:0] i_z,
    input  logic [5:0]              i_present,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [COORD_W-1:0]      o_nu,
    output logic [COORD_W-1:0]      o_nv,
    output logic [COORD_W-1:0]      o_d,
    output t_side                   o_side
);
    logic signed [17:0] sx, sy, sz, ax, ay, az, m, au, av, su, sv;
    logic [2:0] face;
    logic nz, en;
    logic r_v;
    logic [COORD_W-1:0] r_nu, r_nv, r_d;
    t_side r_side;

    always_comb begin
        sx = 18'(i_x);
        sy = 18'(i_y);
        sz = 18'(i_z);
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
        nz = (ax != 0) || (ay != 0) || (az != 0);
        if (ay >= ax && ay >= az) begin
            m  = ay;
            au = sx;
            if (sy > 0) begin
                face = FACE_TOP;
                av   = sz;
            end else begin
                face = FACE_BOTTOM;
                av   = -sz;
            end
        end else if (ax >= az) begin
            m  = ax;
            av = sy;
            if (sx < 0) begin
                face = FACE_LEFT;
                au   = -sz;
            end else begin
                face = FACE_RIGHT;
                au   = sz;
            end
        end else begin
            m  = az;
            av = sy;
            if (sz < 0) begin
                face = FACE_FRONT;
                au   = sx;
            end else begin
                face = FACE_BACK;
                au   = -sx;
            end
        end
        su = m + au;
        sv = m + av;
    end

    assign en      = !r_v || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
        if (en) begin
            r_nu        <= su[COORD_W-1:0];
            r_nv        <= sv[COORD_W-1:0];
            r_d         <= {m[COORD_W-2:0], 1'b0};
            r_side.face <= nz ? face : FACE_BOTTOM;
            r_side.hit  <= nz && i_present[face];
        end
    end

    assign o_valid = r_v;
    assign o_nu    = r_nu;
    assign o_nv    = r_nv;
    assign o_d     = r_d;
    assign o_side  = r_side;
endmodule

@@ sv/cmta_div.sv @@
// two-lane pipelined restoring divider, one quotient bit per stage
module cmta_div import cmta_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_nu,
    input  logic [COORD_W-1:0] i_nv,
    input  logic [COORD_W-1:0] i_d,
    input  t_side              i_side,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_qu,
    output logic [COORD_W-1:0] o_qv,
    output t_side              o_side
);
    localparam int STEPS = COORD_W;

    // dividend is n * 65536 + m; the top bits start as the remainder
    logic               r_v    [STEPS];
    t_lane              r_u    [STEPS];
    t_lane              r_w    [STEPS];
    logic [COORD_W-1:0] r_d    [STEPS];
    t_side              r_side [STEPS];
    logic               en     [STEPS+1];

    assign en[STEPS] = i_ready;

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        localparam int PREV = (k == 0) ? 0 : k - 1;

        t_lane              pu, pw;
        logic [COORD_W-1:0] pd;
        t_side              ps;
        logic               pv;

        always_comb begin
            if (k == 0) begin
                pu = '{rem: {1'b0, i_nu[COORD_W-1:1]},
                       low: {i_nu[0], i_d[COORD_W-1:1]}, q: '0};
                pw = '{rem: {1'b0, i_nv[COORD_W-1:1]},
                       low: {i_nv[0], i_d[COORD_W-1:1]}, q: '0};
                pd = i_d;
                ps = i_side;
                pv = i_valid;
            end else begin
                pu = r_u[PREV];
                pw = r_w[PREV];
                pd = r_d[PREV];
                ps = r_side[PREV];
                pv = r_v[PREV];
            end
        end

        assign en[k] = !r_v[k] || en[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= pv;
            end
            if (en[k]) begin
                r_u[k]    <= div_step(pu, pd);
                r_w[k]    <= div_step(pw, pd);
                r_d[k]    <= pd;
                r_side[k] <= ps;
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[STEPS-1];
    assign o_qu    = r_u[STEPS-1].q;
    assign o_qv    = r_w[STEPS-1].q;
    assign o_side  = r_side[STEPS-1];
endmodule

@@ sv/cmta_texel.sv @@
// scale about centre, clamp, texel rounding and element offset, five stages
module cmta_texel import cmta_pkg::*; #(
    parameter int CHANNELS = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_qu,
    input  logic [COORD_W-1:0] i_qv,
    input  t_side              i_side,
    input  logic [SCALE_W-1:0] i_scale,
    input  logic [DIM_W-1:0]   i_w,
    input  logic [DIM_W-1:0]   i_h,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_hit,
    output logic [2:0]         o_face,
    output logic [TEX_W-1:0]   o_col,
    output logic [TEX_W-1:0]   o_row,
    output logic [OFF_W-1:0]   o_off
);
    localparam int NST = 5;

    logic  r_v [NST];
    t_side r_s [NST];
    logic  en  [NST+1];

    logic signed [34:0] r_tu, r_tv;
    logic [COORD_W-1:0] r_cu, r_cv;
    logic [TEX_W-1:0]   r_col3, r_row3, r_col4, r_col5, r_row4, r_row5;
    logic [25:0]        r_lin;
    logic [OFF_W-1:0]   r_off;

    logic signed [34:0] n_tu, n_tv;
    logic [COORD_W-1:0] n_cu, n_cv;
    logic [29:0]        pu, pv;
    logic [TEX_W-1:0]   wm1, hm1;

    function automatic logic [COORD_W-1:0] round_clamp(logic signed [34:0] t);
        logic signed [35:0] s;
        s = (36'(t) + 36'sd8192) >>> 14;
        s = s + 36'sd32768;
        if (s < 0) begin
            return '0;
        end else if (s > 36'sd65536) begin
            return COORD_W'(65536);
        end
        return s[COORD_W-1:0];
    endfunction

    always_comb begin
        n_tu = 35'(signed'({1'b0, i_qu}) - 18'sd32768) * 35'(signed'({1'b0, i_scale}));
        n_tv = 35'(signed'({1'b0, i_qv}) - 18'sd32768) * 35'(signed'({1'b0, i_scale}));
        n_cu = round_clamp(r_tu);
        n_cv = round_clamp(r_tv);
        wm1  = TEX_W'(i_w - DIM_W'(1));
        hm1  = TEX_W'(i_h - DIM_W'(1));
        pu   = 30'(r_cu) * 30'(wm1) + 30'd32768;
        pv   = 30'(r_cv) * 30'(hm1) + 30'd32768;
    end

    assign en[NST] = i_ready;
    for (genvar k = 0; k < NST; k++) begin : g_ctl
        assign en[k] = !r_v[k] || en[k+1];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k-1];
            end
            if (en[k]) begin
                r_s[k] <= (k == 0) ? i_side : r_s[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_tu <= n_tu;
            r_tv <= n_tv;
        end
        if (en[1]) begin
            r_cu <= n_cu;
            r_cv <= n_cv;
        end
        if (en[2]) begin
            r_col3 <= pu[27:16];
            r_row3 <= pv[27:16];
        end
        if (en[3]) begin
            r_lin  <= 26'(r_row3) * 26'(i_w) + 26'(r_col3);
            r_col4 <= r_col3;
            r_row4 <= r_row3;
        end
        if (en[4]) begin
            r_off  <= OFF_W'(r_lin * 26'(CHANNELS));
            r_col5 <= r_col4;
            r_row5 <= r_row4;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];
    assign o_hit   = r_s[NST-1].hit;
    assign o_face  = r_s[NST-1].face;
    // no hit gives zero coordinates and offset
    assign o_col   = r_s[NST-1].hit ? r_col5 : '0;
    assign o_row   = r_s[NST-1].hit ? r_row5 : '0;
    assign o_off   = r_s[NST-1].hit ? r_off  : '0;
endmodule

@@ sv/cube_map_texel_address.sv @@
// pipeline: 1 select, 17 divide and 5 texel stages from accepted input word to result word
// throughput: one word per cycle while m_axis_tready stays high, set by the one-bit-per-stage divider pipeline
// each stage holds its word under back-pressure and refills as soon as it moves on
// reset (i_rst_n low, synchronous) empties the pipeline and loads register defaults
// defaults: face width and height 512, sample scale 1.0, no faces present
`include "cube_map_texel_address_defines.svh"
module cube_map_texel_address import cmta_pkg::*; #(
    parameter int CHANNELS     = 3,
    parameter int MAX_FACE_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // dir_x, dir_y, dir_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // face_index, texel_col, texel_row, element_offset
    output logic [0:0]  m_axis_tuser,  // hit
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [DIM_W-1:0]   r_fw, r_fh, dw, dh;
    logic [SCALE_W-1:0] r_scale;
    logic [5:0]         r_present;
    logic [1:0]         idx;

    logic               f_v, f_rdy, d_v, d_rdy, t_rdy;
    logic [COORD_W-1:0] f_nu, f_nv, f_d, d_qu, d_qv;
    t_side              f_side, d_side;
    logic               hit;
    logic [2:0]         face;
    logic [TEX_W-1:0]   col, row;
    logic [OFF_W-1:0]   off;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw      <= DIM_W'(512);
            r_fh      <= DIM_W'(512);
            r_scale   <= SCALE_W'(16384);
            r_present <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_FACE_WIDTH:   r_fw      <= pwdata[DIM_W-1:0];
                REG_FACE_HEIGHT:  r_fh      <= pwdata[DIM_W-1:0];
                REG_SAMPLE_SCALE: r_scale   <= pwdata[SCALE_W-1:0];
                REG_FACE_PRESENT: r_present <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FACE_WIDTH:   prdata = 32'(r_fw);
            REG_FACE_HEIGHT:  prdata = 32'(r_fh);
            REG_SAMPLE_SCALE: prdata = 32'(r_scale);
            REG_FACE_PRESENT: prdata = 32'(r_present);
            default:          prdata = '0;
        endcase
    end

    // zero acts as one, oversize as the largest face
    always_comb begin
        dw = (r_fw == '0) ? DIM_W'(1) :
             (r_fw > DIM_W'(MAX_FACE_DIM)) ? DIM_W'(MAX_FACE_DIM) : r_fw;
        dh = (r_fh == '0) ? DIM_W'(1) :
             (r_fh > DIM_W'(MAX_FACE_DIM)) ? DIM_W'(MAX_FACE_DIM) : r_fh;
    end

    cmta_face u_face (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_x       (s_axis_tdata[15:0]),
        .i_y       (s_axis_tdata[31:16]),
        .i_z       (s_axis_tdata[47:32]),
        .i_present (r_present),
        .o_valid   (f_v),
        .i_ready   (f_rdy),
        .o_nu      (f_nu),
        .o_nv      (f_nv),
        .o_d       (f_d),
        .o_side    (f_side)
    );

    cmta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_v),
        .o_ready (f_rdy),
        .i_nu    (f_nu),
        .i_nv    (f_nv),
        .i_d     (f_d),
        .i_side  (f_side),
        .o_valid (d_v),
        .i_ready (d_rdy),
        .o_qu    (d_qu),
        .o_qv    (d_qv),
        .o_side  (d_side)
    );

    cmta_texel #(.CHANNELS(CHANNELS)) u_texel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_v),
        .o_ready (t_rdy),
        .i_qu    (d_qu),
        .i_qv    (d_qv),
        .i_side  (d_side),
        .i_scale (r_scale),
        .i_w     (dw),
        .i_h     (dh),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_hit   (hit),
        .o_face  (face),
        .o_col   (col),
        .o_row   (row),
        .o_off   (off)
    );

    assign d_rdy        = t_rdy;
    assign m_axis_tuser = hit;
    assign m_axis_tdata = {3'b000, off, row, col, face};

    `ASSERT_PROP(a_miss_zero, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[52:3] == '0))
    `ASSERT_NEVER(a_face_range, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[2:0] > FACE_RIGHT))
    `ASSERT_PROP(a_empty_ready, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready)
endmodule

@@ dv/testbench.sv @@
// self-checking stream testbench for the cube map texel address block
module testbench import cmta_pkg::*;;

    localparam int NUM_CH     = 3;
    localparam int MAX_DIM    = 4096;
    localparam int LATENCY    = 23;
    localparam int CYCLE_CAP  = 400000;
    localparam int RAND_WORDS = 830;

    typedef struct packed {
        logic        hit;
        logic [2:0]  face;
        logic [11:0] col;
        logic [11:0] row;
        logic [25:0] off;
    } t_texel;

    typedef struct {
        logic [15:0] x, y, z;
        bit          known;
        t_texel      res;
    } t_row_stim;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;  // dir_x, dir_y, dir_z
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;  // face_index, texel_col, texel_row, element_offset
    logic [0:0]  m_axis_tuser;  // hit
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cube_map_texel_address dut (.*);

    // predictor's copy of the registers
    logic [12:0] cfg_width, cfg_height;
    logic [15:0] cfg_scale;
    logic [5:0]  cfg_present;

    t_texel texel_queue[$];
    int     mismatches;
    int     results_seen;
    int     cycle_count;
    bit     rx_hold_long;
    bit     rx_calm;
    bit     tx_calm;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic longint uv_coord(longint m, longint a);
        return ((m + a) * 65536 + m) / (2 * m);
    endfunction

    function automatic longint scaled(longint c);
        longint t, o;
        t = (c - 32768) * longint'(cfg_scale);
        o = 32768 + ((t + 8192) >>> 14);
        if (o < 0) o = 0;
        if (o > 65536) o = 65536;
        return o;
    endfunction

    function automatic t_texel lookup_texel(logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
        t_texel r;
        longint x, y, z, ax, ay, az, u, v, w, h, col, row;
        logic [2:0] f;
        r = '0;
        x = longint'($signed(dx));
        y = longint'($signed(dy));
        z = longint'($signed(dz));
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        az = z < 0 ? -z : z;
        if (ax == 0 && ay == 0 && az == 0) return r;
        if (ay >= ax && ay >= az) begin
            if (y > 0) begin
                f = FACE_TOP; u = uv_coord(ay, x); v = uv_coord(ay, z);
            end else begin
                f = FACE_BOTTOM; u = uv_coord(ay, x); v = uv_coord(ay, -z);
            end
        end else if (ax >= az) begin
            if (x < 0) begin
                f = FACE_LEFT; u = uv_coord(ax, -z); v = uv_coord(ax, y);
            end else begin
                f = FACE_RIGHT; u = uv_coord(ax, z); v = uv_coord(ax, y);
            end
        end else begin
            if (z < 0) begin
                f = FACE_FRONT; u = uv_coord(az, x); v = uv_coord(az, y);
            end else begin
                f = FACE_BACK; u = uv_coord(az, -x); v = uv_coord(az, y);
            end
        end
        r.face = f;
        if (!cfg_present[f]) return r;
        w = cfg_width == 0 ? 1 : (cfg_width > MAX_DIM ? MAX_DIM : cfg_width);
        h = cfg_height == 0 ? 1 : (cfg_height > MAX_DIM ? MAX_DIM : cfg_height);
        col = (scaled(u) * (w - 1) + 32768) >> 16;
        row = (scaled(v) * (h - 1) + 32768) >> 16;
        r.hit = 1'b1;
        r.col = col[11:0];
        r.row = row[11:0];
        r.off = 26'((row * w + col) * NUM_CH);
        return r;
    endfunction

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FACE_WIDTH:   cfg_width   = val[12:0];
            REG_FACE_HEIGHT:  cfg_height  = val[12:0];
            REG_SAMPLE_SCALE: cfg_scale   = val[15:0];
            default:          cfg_present = val[5:0];
        endcase
    endtask

    task automatic set_regs(logic [12:0] w, logic [12:0] h, logic [15:0] s, logic [5:0] p);
        reg_write(REG_FACE_WIDTH, 32'(w));
        reg_write(REG_FACE_HEIGHT, 32'(h));
        reg_write(REG_SAMPLE_SCALE, 32'(s));
        reg_write(REG_FACE_PRESENT, 32'(p));
    endtask

    task automatic drain_pipe();
        while (texel_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // offers one word, idling first in bursts unless calm; queues the prediction on accept
    task automatic send_dir(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            bit known, t_texel res);
        int gap;
        if (!tx_calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        texel_queue.push_back(known ? res : lookup_texel(x, y, z));
    endtask

    function automatic logic [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 7)) - 16'd3;
            2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            default: return 16'($signed(16'($urandom_range(0, 400))) - 16'sd200);
        endcase
    endfunction

    // receiver side: random burst stalls, one long hold-off on request
    initial begin
        int hold;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_long) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                rx_hold_long = 1'b0;
            end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
                repeat (hold - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_texel got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser[0], m_axis_tdata[2:0], m_axis_tdata[14:3],
                   m_axis_tdata[26:15], m_axis_tdata[52:27]};
            results_seen++;
            if (texel_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                want = texel_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected hit %b face %0d col %0d row %0d off %0d",
                                 want.hit, want.face, want.col, want.row, want.off);
                        $display("          got hit %b face %0d col %0d row %0d off %0d",
                                 got.hit, got.face, got.col, got.row, got.off);
                    end
                end
            end
        end
    end

    initial begin
        t_row_stim dir_table[$];
        int mode;
        logic [15:0] a, b, c;
        mismatches    = 0;
        results_seen  = 0;
        cycle_count   = 0;
        rx_hold_long  = 1'b0;
        rx_calm       = 1'b0;
        tx_calm       = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cfg_width = 13'd512; cfg_height = 13'd512; cfg_scale = 16'd16384; cfg_present = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset no face is loaded, so only the face shows
        dir_table = '{
            '{16'd0, 16'd0, 16'd0, 1'b1, t_texel'{1'b0, FACE_BOTTOM, 12'd0, 12'd0, 26'd0}},
            '{16'd0, 16'd5, 16'd0, 1'b1, t_texel'{1'b0, FACE_TOP, 12'd0, 12'd0, 26'd0}},
            '{16'd0, 16'hfffb, 16'd0, 1'b1, t_texel'{1'b0, FACE_BOTTOM, 12'd0, 12'd0, 26'd0}},
            '{16'h8000, 16'd0, 16'd0, 1'b1, t_texel'{1'b0, FACE_LEFT, 12'd0, 12'd0, 26'd0}},
            '{16'h7fff, 16'd0, 16'd0, 1'b1, t_texel'{1'b0, FACE_RIGHT, 12'd0, 12'd0, 26'd0}},
            '{16'd0, 16'd0, 16'h8000, 1'b1, t_texel'{1'b0, FACE_FRONT, 12'd0, 12'd0, 26'd0}},
            '{16'd0, 16'd0, 16'h7fff, 1'b1, t_texel'{1'b0, FACE_BACK, 12'd0, 12'd0, 26'd0}},
            '{16'd7, 16'd7, 16'd7, 1'b1, t_texel'{1'b0, FACE_TOP, 12'd0, 12'd0, 26'd0}},
            '{16'd7, 16'd3, 16'hfff9, 1'b1, t_texel'{1'b0, FACE_RIGHT, 12'd0, 12'd0, 26'd0}}
        };
        foreach (dir_table[i]) send_dir(dir_table[i].x, dir_table[i].y, dir_table[i].z,
                                        dir_table[i].known, dir_table[i].res);
        s_axis_tvalid <= 1'b0;
        drain_pipe();

        // all faces and then faces 1, 3 and 5 loaded, width and height at the limits and beyond
        set_regs(13'd0, 13'd8191, 16'd65535, 6'h3f);
        dir_table = '{
            '{16'h8000, 16'h8000, 16'h7fff, 1'b0, '0},
            '{16'h7fff, 16'h8001, 16'h8000, 1'b0, '0},
            '{16'h8000, 16'h7fff, 16'h7fff, 1'b0, '0},
            '{16'h7fff, 16'h0001, 16'h8001, 1'b0, '0},
            '{16'h0100, 16'hff00, 16'h00ff, 1'b0, '0},
            '{16'hffff, 16'h0000, 16'h0001, 1'b0, '0},
            '{16'h1234, 16'hedcb, 16'h7000, 1'b0, '0},
            '{16'h0001, 16'h0000, 16'h0000, 1'b0, '0}
        };
        foreach (dir_table[i]) send_dir(dir_table[i].x, dir_table[i].y, dir_table[i].z,
                                        1'b0, '0);
        s_axis_tvalid <= 1'b0;
        drain_pipe();
        set_regs(13'd4096, 13'd1, 16'd0, 6'h2a);
        foreach (dir_table[i]) send_dir(dir_table[i].x, dir_table[i].y, dir_table[i].z,
                                        1'b0, '0);
        s_axis_tvalid <= 1'b0;
        drain_pipe();

        // random phases with varied registers; receiver holds off once in phase one
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_regs(13'd512, 13'd512, 16'd16384, 6'h3f);
                1: set_regs(13'd4096, 13'd4096, 16'd65535, 6'h3f);
                2: set_regs(13'd1, 13'd7, 16'd0, 6'h15);
                3: set_regs(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                            16'($urandom), 6'($urandom));
                4: set_regs(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)),
                            16'($urandom_range(8000, 30000)), 6'h3f);
                default: set_regs(13'd640, 13'd480, 16'd20000, 6'h3f);
            endcase
            if (ph == 1) rx_hold_long = 1'b1;
            if (ph == 5) begin
                rx_calm = 1'b1;
                tx_calm = 1'b1;
            end
            for (int k = 0; k < RAND_WORDS / 6; k++) begin
                mode = $urandom_range(0, 5);
                a = rand_comp(mode % 4);
                b = rand_comp($urandom_range(0, 3));
                c = rand_comp(mode % 4);
                send_dir(a, b, c, 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
            drain_pipe();
        end

        $display("covered %0d result words over directed extremes and six register settings",
                 results_seen);
        $display("including a long receiver stall; %0d mismatches", mismatches);
        if (mismatches == 0 && texel_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
